[src/gshare_bimodal_branch_predictor_top_defines.svh]
// Assertion macros shared by the branch predictor RTL.
// Included by modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef GSHARE_BIMODAL_BRANCH_PREDICTOR_TOP_DEFINES_SVH
`define GSHARE_BIMODAL_BRANCH_PREDICTOR_TOP_DEFINES_SVH

// expression must hold at every edge out of reset
`define GBP_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define GBP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/gbp_pkg.sv]
// Package for the gshare/bimodal branch predictor: widths, codes, types, helpers.
// No dependencies; imported by every predictor module except gbp_ram.
package gbp_pkg;

    localparam int MAX_INDEX_BITS = 14;
    localparam int IDX_W          = MAX_INDEX_BITS;
    localparam int TABLE_DEPTH    = 1 << MAX_INDEX_BITS;
    localparam int CFG_W          = 4;
    localparam int CFG_IDX_W      = 4;
    localparam int ADDR_W         = 32;
    localparam int CNT_W          = 32;
    localparam int CTR_W          = 2;

    localparam logic [CFG_W-1:0] MAX_INDEX_CFG  = CFG_W'(MAX_INDEX_BITS);
    localparam logic [CFG_W-1:0] MIN_INDEX_CFG  = CFG_W'(1);
    localparam logic [CFG_W-1:0] INDEX_BITS_RST = CFG_W'(12);
    localparam logic [CFG_W-1:0] HIST_BITS_RST  = CFG_W'(0);

    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS = CFG_IDX_W'(1);

    localparam logic [CTR_W-1:0] CTR_MIN  = CTR_W'(0);
    localparam logic [CTR_W-1:0] CTR_INIT = CTR_W'(2);
    localparam logic [CTR_W-1:0] CTR_MAX  = CTR_W'(3);

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             taken;
    } gbp_item_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_FETCH,
        BK_UPDATE
    } gbp_back_state_t;

    // low n bits set
    function automatic logic [IDX_W-1:0] low_mask(input logic [CFG_W-1:0] n);
        logic [IDX_W-1:0] mask;
        mask = '0;
        for (int i = 0; i < IDX_W; i++)
        begin
            mask[i] = (i < int'(n));
        end
        return mask;
    endfunction

endpackage

[src/gbp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/gbp_queue.sv]
// Two-entry queue of indexed branches between the front and back ends.
// Depends on gbp_pkg.
module gbp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gbp_pkg::gbp_item_t push_item,
    input  logic              pop,
    output gbp_pkg::gbp_item_t pop_item,
    output logic              full,
    output logic              empty
);
    import gbp_pkg::*;

    gbp_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[src/gbp_front.sv]
// Front end: config registers, index hashing (gshare/bimodal) and global history.
// Depends on gbp_pkg; feeds gbp_queue.
module gbp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gbp_pkg::ADDR_W-1:0]    branch_address,
    input  logic                          actual_taken,
    input  logic                          table_ready,
    input  logic                          queue_full,
    output logic                          push,
    output gbp_pkg::gbp_item_t            push_item
);
    import gbp_pkg::*;

    logic [CFG_W-1:0] index_bits_reg, index_bits_next;
    logic [CFG_W-1:0] hist_bits_reg, hist_bits_next;
    logic [IDX_W-1:0] history_reg, history_next;
    logic [CFG_W-1:0] eff_m;
    logic [CFG_W-1:0] eff_h;
    logic [IDX_W-1:0] imask;
    logic [IDX_W-1:0] hist_used;
    logic [IDX_W-1:0] hist_shifted;
    logic [IDX_W-1:0] insert_bit;

    assign cfg_ready = 1'b1;
    assign in_ready  = table_ready && !queue_full;
    assign push      = in_valid && in_ready;

    always_comb
    begin
        if (index_bits_reg < MIN_INDEX_CFG)
            eff_m = MIN_INDEX_CFG;
        else if (index_bits_reg > MAX_INDEX_CFG)
            eff_m = MAX_INDEX_CFG;
        else
            eff_m = index_bits_reg;
        eff_h = (hist_bits_reg > eff_m) ? eff_m : hist_bits_reg;

        imask        = low_mask(eff_m);
        hist_used    = history_reg & low_mask(eff_h);
        hist_shifted = hist_used << (eff_m - eff_h);

        push_item.idx   = (branch_address[IDX_W+1:2] ^ hist_shifted) & imask;
        push_item.taken = actual_taken;

        insert_bit   = IDX_W'(actual_taken) << (eff_h - CFG_W'(1));
        history_next = history_reg;
        if (push && (eff_h != '0))
            history_next = (history_reg >> 1) | insert_bit;

        index_bits_next = index_bits_reg;
        hist_bits_next  = hist_bits_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_INDEX_BITS:   index_bits_next = cfg_data;
                REG_HISTORY_BITS: hist_bits_next  = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_bits_reg <= INDEX_BITS_RST;
            hist_bits_reg  <= HIST_BITS_RST;
            history_reg    <= '0;
        end
        else
        begin
            index_bits_reg <= index_bits_next;
            hist_bits_reg  <= hist_bits_next;
            history_reg    <= history_next;
        end
    end

endmodule

[src/gbp_back.sv]
// Back end: table clear after reset, counter read-modify-write, totals, result register.
// Depends on gbp_pkg, gbp_ram and the assertion macros header.
module gbp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        queue_empty,
    input  gbp_pkg::gbp_item_t          pop_item,
    output logic                        pop,
    output logic                        table_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        predicted_taken,
    output logic                        mispredicted,
    output logic [gbp_pkg::IDX_W-1:0]   table_index,
    output logic [gbp_pkg::CNT_W-1:0]   prediction_total,
    output logic [gbp_pkg::CNT_W-1:0]   mispredict_total
);
    import gbp_pkg::*;
    `include "gshare_bimodal_branch_predictor_top_defines.svh"

    gbp_back_state_t  state_reg, state_next;
    logic [IDX_W-1:0] clr_addr_reg, clr_addr_next;
    gbp_item_t        cur_reg, cur_next;
    logic [CNT_W-1:0] branch_count_reg, branch_count_next;
    logic [CNT_W-1:0] miss_count_reg, miss_count_next;
    logic             out_valid_reg, out_valid_next;
    logic             pred_reg, miss_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_load;
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr;
    logic [CTR_W-1:0] ram_wdata, ram_rdata;
    logic             pred, miss;
    logic [CTR_W-1:0] ctr_trained;

    gbp_ram #(
        .WIDTH(CTR_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(pop_item.idx),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        pred = (ram_rdata >= CTR_INIT);
        miss = (pred != cur_reg.taken);
        if (cur_reg.taken)
            ctr_trained = (ram_rdata == CTR_MAX) ? CTR_MAX : ram_rdata + CTR_W'(1);
        else
            ctr_trained = (ram_rdata == CTR_MIN) ? CTR_MIN : ram_rdata - CTR_W'(1);

        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        cur_next          = cur_reg;
        branch_count_next = branch_count_reg;
        miss_count_next   = miss_count_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        pop               = 1'b0;
        ram_re            = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = cur_reg.idx;
        ram_wdata         = ctr_trained;
        out_load          = 1'b0;

        case (state_reg)
            BK_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = CTR_INIT;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == '1)
                    state_next = BK_FETCH;
            end
            BK_FETCH:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    ram_re     = 1'b1;
                    cur_next   = pop_item;
                    state_next = BK_UPDATE;
                end
            end
            BK_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ram_we         = 1'b1;
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (branch_count_reg != CNT_MAX)
                        branch_count_next = branch_count_reg + CNT_W'(1);
                    if (miss && (miss_count_reg != CNT_MAX))
                        miss_count_next = miss_count_reg + CNT_W'(1);
                    state_next = BK_FETCH;
                end
            end
            default:
            begin
                state_next = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_CLEAR;
            clr_addr_reg     <= '0;
            branch_count_reg <= '0;
            miss_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            branch_count_reg <= branch_count_next;
            miss_count_reg   <= miss_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (out_load)
        begin
            pred_reg <= pred;
            miss_reg <= miss;
            idx_reg  <= cur_reg.idx;
        end
    end

    assign table_ready      = (state_reg != BK_CLEAR);
    assign out_valid        = out_valid_reg;
    assign predicted_taken  = pred_reg;
    assign mispredicted     = miss_reg;
    assign table_index      = idx_reg;
    assign prediction_total = branch_count_reg;
    assign mispredict_total = miss_count_reg;

    `GBP_ASSERT_IMPLIES(a_no_work_while_clearing, state_reg == BK_CLEAR, !pop && !out_load,
        "branch processed during table clear")
    `GBP_ASSERT_HOLDS(a_miss_le_total, miss_count_reg <= branch_count_reg,
        "mispredict total exceeds prediction total")
    `GBP_ASSERT_NEXT(a_total_advances, out_load,
        (branch_count_reg == $past(branch_count_reg) + CNT_W'(1)) || (branch_count_reg == CNT_MAX),
        "prediction total did not advance on result")
    `GBP_ASSERT_NEXT(a_fetch_to_update, (state_reg == BK_FETCH) && !queue_empty,
        state_reg == BK_UPDATE, "queued branch not taken into update")

endmodule

[src/gshare_bimodal_branch_predictor_top.sv]
// Top level of the gshare/bimodal branch predictor with 2-bit counters.
// Depends on gbp_pkg, gbp_front, gbp_queue, gbp_back (which holds gbp_ram).
//
//  channel | handshake             | payload
//  cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//  in      | in_valid/in_ready     | branch_address, actual_taken
//  out     | out_valid/out_ready   | predicted_taken, mispredicted, table_index, totals
//
// After reset the counter table is swept to weakly taken, all 16384 entries, with in_ready low.
// Config writes are taken every cycle. In the back end each branch is read from the
// counter RAM in BK_FETCH, then trained and written in BK_UPDATE, one branch at a time.
// A two-entry queue lets the front accept until full while the back stalls on out_ready;
// a result waits in the output register and blocks the next update only.
module gshare_bimodal_branch_predictor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gbp_pkg::ADDR_W-1:0]    branch_address,
    input  logic                          actual_taken,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          predicted_taken,
    output logic                          mispredicted,
    output logic [gbp_pkg::IDX_W-1:0]     table_index,
    output logic [gbp_pkg::CNT_W-1:0]     prediction_total,
    output logic [gbp_pkg::CNT_W-1:0]     mispredict_total
);
    import gbp_pkg::*;

    logic      table_ready;
    logic      queue_full;
    logic      queue_empty;
    logic      push;
    logic      pop;
    gbp_item_t push_item;
    gbp_item_t pop_item;

    gbp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .branch_address(branch_address),
        .actual_taken  (actual_taken),
        .table_ready   (table_ready),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    gbp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .pop_item (pop_item),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    gbp_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_empty     (queue_empty),
        .pop_item        (pop_item),
        .pop             (pop),
        .table_ready     (table_ready),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .predicted_taken (predicted_taken),
        .mispredicted    (mispredicted),
        .table_index     (table_index),
        .prediction_total(prediction_total),
        .mispredict_total(mispredict_total)
    );

endmodule
